// ===== hdl/lrudk_pkg.sv =====
// Shared types, widths and codes for the draw key cache.
`timescale 1ns / 1ps
`default_nettype none
package lrudk_pkg;

	// Field widths fixed by the item layout
	localparam int REF_BITS    = 48;
	localparam int COUNT_BITS  = 24;
	localparam int FMT_BITS    = 8;
	localparam int STAMP_W     = 64;
	localparam int SLOT_W      = 7;
	localparam int PURGE_W     = 8;
	localparam int ENTRIES_DEF = 128;

	// Opcodes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INVAL  = 1'b1;

	// Index kinds; this code and above are unsupported
	localparam logic [1:0] KIND_FIRST_BAD = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_HIT    = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_INVAL  = 2'd3;

	typedef struct packed {
		logic                  opcode;
		logic [REF_BITS-1:0]   position_ref;
		logic [REF_BITS-1:0]   normal_ref;
		logic [REF_BITS-1:0]   color_ref;
		logic [REF_BITS-1:0]   texcoord0_ref;
		logic [REF_BITS-1:0]   texcoord1_ref;
		logic [REF_BITS-1:0]   index_ref;
		logic [COUNT_BITS-1:0] vertex_total;
		logic [COUNT_BITS-1:0] index_total;
		logic [1:0]            index_kind;
		logic [4:0]            attribute_mask;
		logic [1:0]            color_kind;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_live;
		logic [PURGE_W-1:0] purged_total;
	} out_word_t;

	// One stored key entry
	typedef struct packed {
		logic [REF_BITS-1:0]   pos;
		logic [REF_BITS-1:0]   nrm;
		logic [REF_BITS-1:0]   col;
		logic [REF_BITS-1:0]   tc0;
		logic [REF_BITS-1:0]   tc1;
		logic [REF_BITS-1:0]   idx;
		logic [COUNT_BITS-1:0] vtot;
		logic [COUNT_BITS-1:0] itot;
		logic [FMT_BITS-1:0]   fmt;
	} key_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic reject;
		logic scan_last;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ===== hdl/lrudk_ctrl.sv =====
// Sequencer for the draw key cache: load, scan, drain, commit.
`timescale 1ns / 1ps
`default_nettype none
module lrudk_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire lrudk_pkg::ctl_sts_t sts,
	output lrudk_pkg::ctl_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Decode next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = sts.reject ? S_COMMIT : S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_last) state_nxt = S_DRAIN;
			end
			S_DRAIN:  state_nxt = S_COMMIT;
			S_COMMIT: state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Drive datapath commands
	always_comb begin
		cmd.load   = accept;
		cmd.scan   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT);
	end

endmodule
`default_nettype wire

// ===== hdl/lrudk_datapath.sv =====
// Key and stamp stores, valid bits, scan compare and result register.
`timescale 1ns / 1ps
`default_nettype none
module lrudk_datapath #(
	parameter int ENTRIES = lrudk_pkg::ENTRIES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lrudk_pkg::in_word_t  req,
	input  wire lrudk_pkg::ctl_cmd_t  cmd,
	output lrudk_pkg::ctl_sts_t       sts,
	output lrudk_pkg::out_word_t      rsp,
	output logic                      done
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// Stores
	lrudk_pkg::key_t              key_mem   [ENTRIES];
	logic [lrudk_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];
	logic [ENTRIES-1:0]           valid_q;

	// Item held for the scan
	lrudk_pkg::key_t key_q;
	logic            inval_q;
	logic            reject_q;

	// Scan pointer and read stage
	logic [IDX_W-1:0]              idx_q;
	logic                          act_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          vld_s1;
	lrudk_pkg::key_t               key_s1;
	logic [lrudk_pkg::STAMP_W-1:0] stamp_s1;

	// Accumulators
	logic                          found_q;
	logic                          free_q;
	logic [IDX_W-1:0]              hit_q;
	logic [IDX_W-1:0]              victim_q;
	logic [lrudk_pkg::STAMP_W-1:0] oldest_q;
	logic [CNT_W-1:0]              purged_q;
	logic [lrudk_pkg::STAMP_W-1:0] use_clock_q;

	lrudk_pkg::out_word_t          rsp_q;
	lrudk_pkg::out_word_t          rsp_nxt;
	logic                          done_q;

	lrudk_pkg::key_t               key_in;
	logic                          key_match;
	logic                          holds_addr;
	logic                          purge_now;
	logic                          do_fill;
	logic                          do_stamp;
	logic [IDX_W-1:0]              stamp_addr;
	logic [lrudk_pkg::STAMP_W-1:0] clock_nxt;

	// Form the key from the incoming word
	always_comb begin
		key_in.pos  = req.position_ref;
		key_in.nrm  = req.normal_ref;
		key_in.col  = req.color_ref;
		key_in.tc0  = req.texcoord0_ref;
		key_in.tc1  = req.texcoord1_ref;
		key_in.idx  = req.index_ref;
		key_in.vtot = req.vertex_total;
		key_in.itot = req.index_total;
		key_in.fmt  = {req.color_kind, req.attribute_mask, req.index_kind[0]};
	end

	assign sts.reject    = (req.opcode == lrudk_pkg::OP_LOOKUP) &&
	                       (req.index_kind >= lrudk_pkg::KIND_FIRST_BAD);
	assign sts.scan_last = (idx_q == LAST_IDX);

	// Compare the entry read last cycle
	assign key_match  = (key_s1 == key_q);
	assign holds_addr = (key_s1.pos == key_q.pos) || (key_s1.nrm == key_q.pos) ||
	                    (key_s1.col == key_q.pos) || (key_s1.tc0 == key_q.pos) ||
	                    (key_s1.tc1 == key_q.pos) || (key_s1.idx == key_q.pos);
	assign purge_now  = act_s1 && inval_q && vld_s1 && holds_addr;

	assign do_stamp   = cmd.commit && !inval_q && !reject_q;
	assign do_fill    = do_stamp && !found_q;
	assign stamp_addr = found_q ? hit_q : victim_q;
	assign clock_nxt  = use_clock_q + lrudk_pkg::STAMP_W'(1);

	// Key store: fill on miss, read at scan pointer
	always_ff @(posedge clk) begin
		if (do_fill) key_mem[victim_q] <= key_q;
		if (cmd.scan) key_s1 <= key_mem[idx_q];
	end

	// Stamp store: refresh on hit or fill, read at scan pointer
	always_ff @(posedge clk) begin
		if (do_stamp) stamp_mem[stamp_addr] <= clock_nxt;
		if (cmd.scan) stamp_s1 <= stamp_mem[idx_q];
	end

	// Valid bits: clear on purge, set on fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (purge_now) valid_q[idx_s1] <= 1'b0;
			if (do_fill) valid_q[victim_q] <= 1'b1;
		end
	end

	// Capture item, advance scan pointer, track read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inval_q  <= 1'b0;
			reject_q <= 1'b0;
			idx_q    <= '0;
			act_s1   <= 1'b0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
		end else begin
			if (cmd.load) begin
				inval_q  <= (req.opcode == lrudk_pkg::OP_INVAL);
				reject_q <= sts.reject;
				idx_q    <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			act_s1 <= cmd.scan;
			if (cmd.scan) begin
				idx_s1 <= idx_q;
				vld_s1 <= valid_q[idx_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) key_q <= key_in;
	end

	// Accumulate hit, victim and purge count over the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			hit_q    <= '0;
			victim_q <= '0;
			oldest_q <= '1;
			purged_q <= '0;
		end else if (cmd.load) begin
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			hit_q    <= '0;
			victim_q <= '0;
			oldest_q <= '1;
			purged_q <= '0;
		end else if (act_s1) begin
			if (inval_q) begin
				if (purge_now) purged_q <= purged_q + CNT_W'(1);
			end else if (vld_s1) begin
				if (!found_q && key_match) begin
					found_q <= 1'b1;
					hit_q   <= idx_s1;
				end
				if (!free_q && (stamp_s1 < oldest_q)) begin
					oldest_q <= stamp_s1;
					victim_q <= idx_s1;
				end
			end else if (!free_q) begin
				free_q   <= 1'b1;
				victim_q <= idx_s1;
			end
		end
	end

	// Step the use clock on hit or fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_clock_q <= '0;
		end else if (do_stamp) begin
			use_clock_q <= clock_nxt;
		end
	end

	// Register the result word and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	// Form the result word for the item in hand
	always_comb begin
		rsp_nxt = '0;
		if (inval_q) begin
			rsp_nxt.status       = lrudk_pkg::ST_INVAL;
			rsp_nxt.purged_total = lrudk_pkg::PURGE_W'(purged_q);
		end else if (reject_q) begin
			rsp_nxt.status = lrudk_pkg::ST_REJECT;
		end else if (found_q) begin
			rsp_nxt.status = lrudk_pkg::ST_HIT;
			rsp_nxt.slot   = lrudk_pkg::SLOT_W'(hit_q);
		end else begin
			rsp_nxt.status       = lrudk_pkg::ST_MISS;
			rsp_nxt.slot         = lrudk_pkg::SLOT_W'(victim_q);
			rsp_nxt.evicted_live = !free_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) rsp_q <= rsp_nxt;
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== hdl/lru_draw_key_cache.sv =====
// Top level of the fully associative draw key cache with LRU replacement.
// Lookup and invalidate words hold busy through one pass of the scan pointer over the
// single-port key and stamp stores, a drain of the compare stage and a write back;
// done pulses the cycle after. A rejected index kind skips the scan and goes straight
// to write back. A new word may start in the done cycle.
// Reset clears valid bits and the use clock at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module lru_draw_key_cache #(
	parameter int ENTRIES = lrudk_pkg::ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire lrudk_pkg::in_word_t req,
	output logic                     done,
	output lrudk_pkg::out_word_t     rsp
);

	lrudk_pkg::ctl_cmd_t cmd;
	lrudk_pkg::ctl_sts_t sts;

	lrudk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	lrudk_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

endmodule
`default_nettype wire

// ===== hdl/lrudk_checker.sv =====
// Port-level checks for the draw key cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lrudk_checker #(
	parameter int ENTRIES = lrudk_pkg::ENTRIES_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire lrudk_pkg::in_word_t  req,
	input wire logic                 done,
	input wire lrudk_pkg::out_word_t rsp
);

	logic acc_reject;
	logic acc_scan;

	assign acc_reject = start && !busy && (req.opcode == lrudk_pkg::OP_LOOKUP) &&
	                    (req.index_kind >= lrudk_pkg::KIND_FIRST_BAD);
	assign acc_scan   = start && !busy && !acc_reject;

	// Result strobe only while idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Busy drops exactly as a result appears
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// Rejected word skips the scan and answers through the commit state and the registered strobe
	a_reject_lat: assert property (@(posedge clk) disable iff (!arst_n)
		acc_reject |-> ##2 done)
		else $error("reject latency wrong");

	// Scanned word answers after the full pass, drain and write back
	a_scan_lat: assert property (@(posedge clk) disable iff (!arst_n)
		acc_scan |-> ##(ENTRIES + 3) done)
		else $error("scan latency wrong");

	// Reject and invalidate carry no slot and no eviction
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == lrudk_pkg::ST_REJECT || rsp.status == lrudk_pkg::ST_INVAL)
		|-> (rsp.slot == '0) && !rsp.evicted_live)
		else $error("slot or eviction set on reject or invalidate");

endmodule

bind lru_draw_key_cache lrudk_checker #(.ENTRIES(ENTRIES)) u_lrudk_checker (.*);
`default_nettype wire

// ===== tb/sv/lrudk_score_pkg.sv =====
// Scoreboard that predicts and checks the draw key cache results.
`timescale 1ns / 1ps
package lrudk_score_pkg;
	import lrudk_pkg::*;

	class draw_cache_scoreboard;
		bit                 live[ENTRIES_DEF];
		key_t               keys[ENTRIES_DEF];
		logic [STAMP_W-1:0] stamps[ENTRIES_DEF];
		logic [STAMP_W-1:0] use_clock;
		out_word_t          pending_results[$];
		int                 mismatches;

		function new();
			foreach (live[s]) live[s] = 1'b0;
			use_clock  = '0;
			mismatches = 0;
		endfunction

		// Apply one accepted word to the cache image and queue the result it causes
		function void note_request(in_word_t w);
			out_word_t          res;
			key_t               k;
			logic [STAMP_W-1:0] oldest;
			int                 s;
			int                 hit_slot;
			int                 victim;
			int                 purged;
			bit                 free_seen;
			res = '0;
			if (w.opcode == OP_INVAL) begin
				// Drop every live entry that refers to the address in any of its six refs
				purged = 0;
				for (s = 0; s < ENTRIES_DEF; s++) begin
					if (live[s] && (keys[s].pos == w.position_ref ||
							keys[s].nrm == w.position_ref || keys[s].col == w.position_ref ||
							keys[s].tc0 == w.position_ref || keys[s].tc1 == w.position_ref ||
							keys[s].idx == w.position_ref)) begin
						live[s] = 1'b0;
						purged++;
					end
				end
				res.status       = ST_INVAL;
				res.purged_total = PURGE_W'(purged);
			end else if (w.index_kind >= KIND_FIRST_BAD) begin
				res.status = ST_REJECT;
			end else begin
				k.pos  = w.position_ref;
				k.nrm  = w.normal_ref;
				k.col  = w.color_ref;
				k.tc0  = w.texcoord0_ref;
				k.tc1  = w.texcoord1_ref;
				k.idx  = w.index_ref;
				k.vtot = w.vertex_total;
				k.itot = w.index_total;
				k.fmt  = {w.color_kind, w.attribute_mask, w.index_kind[0]};
				// Find the first match and the victim in one pass
				hit_slot  = -1;
				victim    = 0;
				free_seen = 1'b0;
				oldest    = '1;
				for (s = 0; s < ENTRIES_DEF; s++) begin
					if (live[s]) begin
						if (hit_slot < 0 && keys[s] == k)
							hit_slot = s;
						if (!free_seen && stamps[s] < oldest) begin
							oldest = stamps[s];
							victim = s;
						end
					end else if (!free_seen) begin
						free_seen = 1'b1;
						victim    = s;
					end
				end
				use_clock = use_clock + STAMP_W'(1);
				if (hit_slot >= 0) begin
					stamps[hit_slot] = use_clock;
					res.status       = ST_HIT;
					res.slot         = SLOT_W'(hit_slot);
				end else begin
					res.status       = ST_MISS;
					res.slot         = SLOT_W'(victim);
					res.evicted_live = live[victim];
					keys[victim]     = k;
					stamps[victim]   = use_clock;
					live[victim]     = 1'b1;
				end
			end
			pending_results.push_back(res);
		endfunction

		// Compare a result word against the oldest pending one
		function void check_result(out_word_t got);
			out_word_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d slot %0d evicted %0d purged %0d",
						got.status, got.slot, got.evicted_live, got.purged_total);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.slot !== want.slot ||
					got.evicted_live !== want.evicted_live ||
					got.purged_total !== want.purged_total) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want status %0d slot %0d evicted %0d purged %0d, %s",
						want.status, want.slot, want.evicted_live, want.purged_total,
						$sformatf("got status %0d slot %0d evicted %0d purged %0d",
							got.status, got.slot, got.evicted_live, got.purged_total));
			end
		endfunction

		function bit clean();
			return mismatches == 0 && pending_results.size() == 0;
		endfunction
	endclass

endpackage

// ===== tb/sv/lru_draw_key_cache_test.sv =====
// Top-level test of the draw key cache: directed and random words against a scoreboard.
`timescale 1ns / 1ps
module lru_draw_key_cache_test;
	import lrudk_pkg::*;
	import lrudk_score_pkg::*;

	localparam int RANDOM_WORDS = 930;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HISTORY_MAX  = 256;
	localparam int SHARED_REFS  = 16;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  req;
	logic      done;
	out_word_t rsp;

	draw_cache_scoreboard board;
	in_word_t             history[$];
	logic [REF_BITS-1:0]  shared_refs[SHARED_REFS];
	int                   cycles = 0;
	int                   no_gap_left = 0;

	lru_draw_key_cache dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Check every result word on its strobe
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(rsp);
	end

	function automatic logic [REF_BITS-1:0] rand_ref();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[REF_BITS-1:0];
	endfunction

	// Mostly unique addresses, some shared between keys, a few absent
	function automatic logic [REF_BITS-1:0] pick_ref();
		int c;
		c = $urandom_range(0, 99);
		if (c < 86)
			return rand_ref();
		else if (c < 96)
			return shared_refs[$urandom_range(0, SHARED_REFS - 1)];
		return '0;
	endfunction

	function automatic in_word_t fresh_lookup();
		in_word_t w;
		w.opcode         = OP_LOOKUP;
		w.position_ref   = pick_ref();
		w.normal_ref     = pick_ref();
		w.color_ref      = pick_ref();
		w.texcoord0_ref  = pick_ref();
		w.texcoord1_ref  = pick_ref();
		w.index_ref      = pick_ref();
		w.vertex_total   = $urandom_range(0, 1) ? COUNT_BITS'($urandom()) :
			COUNT_BITS'($urandom_range(0, 255));
		w.index_total    = $urandom_range(0, 1) ? COUNT_BITS'($urandom()) :
			COUNT_BITS'($urandom_range(0, 255));
		w.index_kind     = 2'($urandom_range(0, 1));
		w.attribute_mask = 5'($urandom());
		w.color_kind     = 2'($urandom_range(0, 3));
		return w;
	endfunction

	function automatic in_word_t purge_word(logic [REF_BITS-1:0] addr);
		in_word_t w;
		w              = fresh_lookup();
		w.opcode       = OP_INVAL;
		w.index_kind   = 2'($urandom());
		w.position_ref = addr;
		return w;
	endfunction

	// Pick a key used lately, so it is likely still cached
	function automatic in_word_t recent_key();
		int span;
		span = history.size() < 48 ? history.size() : 48;
		return history[history.size() - 1 - $urandom_range(0, span - 1)];
	endfunction

	// Present a word and hold it until the block takes it
	task automatic send_word(input in_word_t w);
		@(negedge clk);
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_request(w);
		if (w.opcode == OP_LOOKUP && w.index_kind < KIND_FIRST_BAD) begin
			history.push_back(w);
			if (history.size() > HISTORY_MAX)
				void'(history.pop_front());
		end
	endtask

	task automatic pause(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Hold off until every pending result has arrived
	task automatic drain();
		pause(1);
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		in_word_t w;
		in_word_t ka;
		int       n;
		int       choice;
		int       field;

		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		board  = new();
		foreach (shared_refs[i]) shared_refs[i] = rand_ref();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: all-zero and all-one keys, then hit again
		w = '0;
		send_word(w);
		send_word(w);
		w            = '1;
		w.opcode     = OP_LOOKUP;
		w.index_kind = 2'd1;
		send_word(w);
		send_word(w);
		// Reject both unsupported index kinds
		w.index_kind = 2'd2;
		send_word(w);
		w.index_kind = 2'd3;
		send_word(w);
		// Near misses on the format bits
		ka = fresh_lookup();
		send_word(ka);
		w = ka;
		w.index_kind[0] = ~w.index_kind[0];
		send_word(w);
		w = ka;
		w.color_kind = 2'd3;
		send_word(w);
		send_word(ka);
		// Purge by an all-ones, an unknown and the zero address
		send_word(purge_word('1));
		send_word(purge_word(rand_ref()));
		send_word(fresh_lookup());
		send_word(purge_word('0));
		w = '0;
		send_word(w);
		// Purge through a non-position ref
		w = '1;
		w.opcode       = OP_INVAL;
		w.position_ref = ka.texcoord1_ref;
		send_word(w);
		w = fresh_lookup();
		w.vertex_total = '1;
		w.index_total  = '0;
		send_word(w);
		send_word(w);
		drain();

		// Random: mostly repeated and fresh keys, some purges and rejects
		for (n = 0; n < RANDOM_WORDS; n++) begin
			choice = $urandom_range(0, 99);
			if (history.size() == 0 || choice < 35) begin
				w = fresh_lookup();
			end else if (choice < 68) begin
				w = recent_key();
			end else if (choice < 78) begin
				// Flip one key bit of a recent key
				w = recent_key();
				w = w ^ (in_word_t'(1) << $urandom_range(0, $bits(in_word_t) - 2));
			end else if (choice < 83) begin
				w = history[$urandom_range(0, history.size() - 1)];
			end else if (choice < 90) begin
				w = recent_key();
				field = $urandom_range(0, 99);
				if (field < 70) begin
					case ($urandom_range(0, 5))
						0: w = purge_word(w.position_ref);
						1: w = purge_word(w.normal_ref);
						2: w = purge_word(w.color_ref);
						3: w = purge_word(w.texcoord0_ref);
						4: w = purge_word(w.texcoord1_ref);
						default: w = purge_word(w.index_ref);
					endcase
					if (w.position_ref == '0)
						w.position_ref = rand_ref();
				end else if (field < 80) begin
					w = purge_word(shared_refs[$urandom_range(0, SHARED_REFS - 1)]);
				end else begin
					w = purge_word(rand_ref());
				end
			end else begin
				w = $urandom_range(0, 1) ? recent_key() : fresh_lookup();
				w.index_kind = KIND_FIRST_BAD | 2'($urandom_range(0, 1));
			end
			send_word(w);

			// Space the words: bursts, short gaps, long gaps and full drains
			if (no_gap_left > 0) begin
				no_gap_left--;
			end else begin
				choice = $urandom_range(0, 99);
				if (choice < 3)
					no_gap_left = $urandom_range(10, 40);
				else if (choice < 5)
					drain();
				else if (choice >= 60 && choice < 88)
					pause($urandom_range(1, 4));
				else if (choice >= 88)
					pause($urandom_range(5, 160));
			end
		end

		drain();
		repeat (ENTRIES_DEF + 10) @(posedge clk);
		if (board.clean())
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
